### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the escape encoder blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define U2H_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define U2H_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`U2H_ASSERT(label, clk, rst_n, !(expr), msg)
`else
`define U2H_ASSERT(label, clk, rst_n, prop, msg)
`define U2H_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hw/rtl/u2h_pkg.sv
// ----------------------------------------------------------------------------
// u2h_pkg
// Types and constants of the UTF-16 to numeric character reference encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2h_pkg;

	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned DEC_W    = 17;
	localparam int unsigned RUN_W    = 4;

	// unit classification thresholds
	localparam logic [UNIT_W-1:0] ASCII_LIMIT    = 16'd128;
	localparam logic [UNIT_W-1:0] FOUR_DIG_MIN   = 16'd1000;
	localparam logic [UNIT_W-1:0] FIVE_DIG_MIN   = 16'd10000;
	localparam logic [UNIT_W-1:0] CAPACITY_RESET = 16'd260;

	// run lengths in bytes
	localparam logic [RUN_W-1:0] RUN_ASCII = 4'd1;
	localparam logic [RUN_W-1:0] RUN_ESC3  = 4'd6;
	localparam logic [RUN_W-1:0] RUN_ESC4  = 4'd7;
	localparam logic [RUN_W-1:0] RUN_ESC5  = 4'd8;

	// most significant digit position per digit count
	localparam logic [POS_W-1:0] TOP_POS3 = 3'd2;
	localparam logic [POS_W-1:0] TOP_POS4 = 3'd3;
	localparam logic [POS_W-1:0] TOP_POS5 = 3'd4;
	localparam logic [POS_W-1:0] LAST_POS = 3'd0;
	localparam logic [POS_W-1:0] MAX_POS  = 3'd4;

	// output characters
	localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
	localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

	// k times ten to the power p, row p, column k
	localparam logic [DEC_W-1:0] DEC_STEP [5][10] = '{
		'{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
		'{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
			17'd90},
		'{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
			17'd800, 17'd900},
		'{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
			17'd7000, 17'd8000, 17'd9000},
		'{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000,
			17'd70000, 17'd80000, 17'd90000}
	};

	// what the back end does with a queued unit
	typedef enum logic [1:0] {
		KIND_ASCII = 2'd0,
		KIND_ESC   = 2'd1,
		KIND_TERM  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [UNIT_W-1:0]  unit;
		logic [POS_W-1:0]   top_pos;
	} entry_t;

endpackage

`default_nettype wire

### hw/rtl/utf16_to_html_numeric_escape.sv
// ----------------------------------------------------------------------------
// utf16_to_html_numeric_escape
// Turns UTF-16 code units into ANSI bytes with numeric character references.
// ----------------------------------------------------------------------------
// Input channel: one code unit per beat (in_valid, in_stall, code_unit).
// Output channel: one byte per beat (out_valid, out_stall, out_byte,
// run_last); run_last marks the final byte produced for a code unit.
// Units below 128 give one byte, a zero unit gives one 0 byte and restarts
// the budget, other units give '&#', 3 to 5 decimal digits and ';'.
// The front end takes a unit every cycle while the queue has room; the
// back end emits one byte per cycle while out_stall is low, so ASCII
// text flows at one unit per cycle and an escaped unit holds the back
// end for 6 to 8 bytes. Each unit passes the queue, then the output register.
// When the byte budget runs below the reserve, nonzero units are accepted
// and dropped until the next terminator or capacity write.
// Writing cfg_wdata with cfg_we sets the capacity and reloads the budget.
// Reset empties the queue and output, sets capacity and budget to 260.
// A stalled output beat holds; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_html_numeric_escape #(
	parameter int unsigned ESCAPE_RESERVE = 9,
	parameter int unsigned QUEUE_DEPTH    = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [u2h_pkg::UNIT_W-1:0]  code_unit,
	input  wire logic                        cfg_we,
	input  wire logic [u2h_pkg::UNIT_W-1:0]  cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [u2h_pkg::BYTE_W-1:0]       out_byte,
	output logic                             run_last
);
	import u2h_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_not_empty;
	entry_t q_entry;
	entry_t q_head;

	// classification and budget
	u2h_front #(
		.ESCAPE_RESERVE(ESCAPE_RESERVE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.code_unit(code_unit),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	// decoupling queue
	u2h_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// byte expansion
	u2h_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

### hw/rtl/u2h_front.sv
// ----------------------------------------------------------------------------
// u2h_front
// Accepts code units, keeps the byte budget and classifies each unit.
// ----------------------------------------------------------------------------
`default_nettype none

module u2h_front #(
	parameter int unsigned ESCAPE_RESERVE = 9
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [u2h_pkg::UNIT_W-1:0]  code_unit,
	input  wire logic                        cfg_we,
	input  wire logic [u2h_pkg::UNIT_W-1:0]  cfg_wdata,
	input  wire logic                        q_full,
	output logic                             q_push,
	output u2h_pkg::entry_t                  q_entry
);
	import u2h_pkg::*;

	localparam logic [UNIT_W-1:0] RESERVE = UNIT_W'(ESCAPE_RESERVE);

	logic [UNIT_W-1:0] capacity_q;
	logic [UNIT_W-1:0] budget_q;
	logic              stopped_q;
	logic              accept;
	logic              is_term;
	logic [RUN_W-1:0]  run_len;
	logic [UNIT_W-1:0] budget_spent;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_term  = (code_unit == '0);

	// classify the unit and size its run
	always_comb begin
		q_entry.unit = code_unit;
		priority if (is_term) begin
			q_entry.kind    = KIND_TERM;
			q_entry.top_pos = LAST_POS;
			run_len         = '0;
		end else if (code_unit < ASCII_LIMIT) begin
			q_entry.kind    = KIND_ASCII;
			q_entry.top_pos = LAST_POS;
			run_len         = RUN_ASCII;
		end else if (code_unit >= FIVE_DIG_MIN) begin
			q_entry.kind    = KIND_ESC;
			q_entry.top_pos = TOP_POS5;
			run_len         = RUN_ESC5;
		end else if (code_unit >= FOUR_DIG_MIN) begin
			q_entry.kind    = KIND_ESC;
			q_entry.top_pos = TOP_POS4;
			run_len         = RUN_ESC4;
		end else begin
			q_entry.kind    = KIND_ESC;
			q_entry.top_pos = TOP_POS3;
			run_len         = RUN_ESC3;
		end
	end

	// terminators always go out, other units only while budget lasts
	assign q_push = accept && (is_term || !stopped_q);

	// saturating budget decrement
	assign budget_spent = (budget_q >= UNIT_W'(run_len)) ? budget_q - UNIT_W'(run_len) : '0;

	// capacity register and budget tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			budget_q   <= CAPACITY_RESET;
			stopped_q  <= (CAPACITY_RESET < RESERVE);
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
			budget_q   <= cfg_wdata;
			stopped_q  <= (cfg_wdata < RESERVE);
		end else if (accept && is_term) begin
			budget_q  <= capacity_q;
			stopped_q <= (capacity_q < RESERVE);
		end else if (q_push) begin
			budget_q  <= budget_spent;
			stopped_q <= (budget_spent < RESERVE);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/u2h_fifo.sv
// ----------------------------------------------------------------------------
// u2h_fifo
// Short queue of classified units between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u2h_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u2h_pkg::entry_t  push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output u2h_pkg::entry_t       head
);
	import u2h_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	entry_t          slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`U2H_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "push into full queue")
	`U2H_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && !not_empty, "pop from empty queue")
	`U2H_ASSERT(a_count_up, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "fill count lost a push")

endmodule

`default_nettype wire

### hw/rtl/u2h_back.sv
// ----------------------------------------------------------------------------
// u2h_back
// Expands queued units into output bytes, one decimal digit per beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u2h_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_not_empty,
	input  wire u2h_pkg::entry_t             q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [u2h_pkg::BYTE_W-1:0]       out_byte,
	output logic                             run_last
);
	import u2h_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_HASH  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_SEMI  = 4'b1000
	} phase_t;

	phase_t              phase_q;
	phase_t              phase_d;
	logic [UNIT_W-1:0]   rem_q;
	logic [UNIT_W-1:0]   rem_d;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_d;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                run_last_q;
	logic                adv;
	logic                have_d;
	logic [BYTE_W-1:0]   byte_d;
	logic                last_d;
	logic [3:0]          digit;
	logic [DEC_W-1:0]    digit_sub;

	assign adv = !out_valid_q || !out_stall;

	// leading digit of the remainder at the current position
	always_comb begin
		digit     = '0;
		digit_sub = '0;
		for (int k = 1; k < 10; k++) begin
			if ({1'b0, rem_q} >= DEC_STEP[pos_q][k]) begin
				digit     = 4'(k);
				digit_sub = DEC_STEP[pos_q][k];
			end
		end
	end

	// byte sequencer
	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		pos_d   = pos_q;
		have_d  = 1'b0;
		byte_d  = CH_NUL;
		last_d  = 1'b0;
		q_pop   = 1'b0;
		if (adv) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (q_not_empty) begin
						q_pop  = 1'b1;
						have_d = 1'b1;
						unique case (q_head.kind)
							KIND_ASCII: begin
								byte_d = {1'b0, q_head.unit[6:0]};
								last_d = 1'b1;
							end
							KIND_ESC: begin
								byte_d  = CH_AMP;
								phase_d = PH_HASH;
								rem_d   = q_head.unit;
								pos_d   = q_head.top_pos;
							end
							default: begin
								byte_d = CH_NUL;
								last_d = 1'b1;
							end
						endcase
					end
				end
				PH_HASH: begin
					have_d  = 1'b1;
					byte_d  = CH_HASH;
					phase_d = PH_DIGIT;
				end
				PH_DIGIT: begin
					have_d = 1'b1;
					byte_d = CH_ZERO | {4'b0000, digit};
					rem_d  = rem_q - digit_sub[UNIT_W-1:0];
					if (pos_q == LAST_POS) begin
						phase_d = PH_SEMI;
					end else begin
						pos_d = pos_q - 1'b1;
					end
				end
				PH_SEMI: begin
					have_d  = 1'b1;
					byte_d  = CH_SEMI;
					last_d  = 1'b1;
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (adv) begin
				out_valid_q <= have_d;
			end
		end
	end

	// working value and output beat
	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		pos_q <= pos_d;
		if (adv && have_d) begin
			out_byte_q <= byte_d;
			run_last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	`U2H_ASSERT(a_pos_range, clk, arst_n, (phase_q == PH_DIGIT) |-> (pos_q <= MAX_POS), "digit position out of range")
	`U2H_ASSERT(a_rem_fits, clk, arst_n, ((phase_q == PH_DIGIT) && (pos_q <= MAX_POS)) |-> ({1'b0, rem_q} < DEC_STEP[pos_q][9] + DEC_STEP[pos_q][1]), "remainder too large for position")
	`U2H_ASSERT(a_pop_idle, clk, arst_n, q_pop |-> (phase_q == PH_IDLE), "queue popped mid run")

endmodule

`default_nettype wire
